/* rtl/fatlb_pkg.sv */
// Shared constants, types and result layout for the FIFO-replacement fully associative TLB.
package fatlb_pkg;

  localparam int ENTRIES      = 8;
  localparam int ADDRESS_BITS = 32;
  localparam int OFFSET_BITS  = 12;

  localparam int VaWidth      = 32;
  localparam int PnWidth      = 20;
  localparam int PoWidth      = 12;
  localparam int SlotWidth    = 3;

  localparam int KeyBits   = (ADDRESS_BITS < VaWidth) ? ADDRESS_BITS : VaWidth;
  localparam int SlotBits  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CountBits = $clog2(ENTRIES + 1);
  localparam int SumBits   = SlotBits + 1;

  localparam logic [63:0] OffsetMask64 =
    (OFFSET_BITS >= 64) ? {64{1'b1}} : ((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [KeyBits-1:0] OffsetMask = OffsetMask64[KeyBits-1:0];

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [CountBits-1:0] count_t;

  typedef struct packed {
    logic  hit;
    slot_t slot;
    logic  evicted;
    key_t  evicted_address;
  } lookup_t;

  typedef struct packed {
    logic                 hit;
    logic [PnWidth-1:0]   page_number;
    logic [PoWidth-1:0]   page_offset;
    logic [SlotWidth-1:0] slot;
    logic                 evicted;
    logic [VaWidth-1:0]   evicted_address;
  } result_t;

endpackage

/* rtl/fatlb_if.sv */
// Valid/ready channel interfaces for address requests and translation results.
interface fatlb_req_if;
  logic                             valid;
  logic                             ready;
  logic [fatlb_pkg::VaWidth-1:0]    virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface fatlb_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [fatlb_pkg::PnWidth-1:0]    page_number;
  logic [fatlb_pkg::PoWidth-1:0]    page_offset;
  logic [fatlb_pkg::SlotWidth-1:0]  slot;
  logic                             evicted;
  logic [fatlb_pkg::VaWidth-1:0]    evicted_address;

  modport source (output valid, output hit, output page_number, output page_offset,
                  output slot, output evicted, output evicted_address, input ready);
  modport sink   (input valid, input hit, input page_number, input page_offset,
                  input slot, input evicted, input evicted_address, output ready);
endinterface

/* rtl/fifo_fully_associative_tlb.sv */
// Fully associative TLB, 8 entries, FIFO replacement: one address per cycle unless the
// output stalls. An address passes the input register, a parallel compare of all entries
// that also updates the table, then the result register; the table needs no clearing pass.
module fifo_fully_associative_tlb (
  input  logic clk,
  input  logic rst,
  fatlb_req_if.sink   req,
  fatlb_rsp_if.source rsp
);
  import fatlb_pkg::*;

  logic    in_valid;
  key_t    in_key;
  logic    out_valid;
  result_t out_res;

  logic    advance;
  logic    process;
  lookup_t look;
  result_t res_next;

  assign advance   = !out_valid || rsp.ready;
  assign process   = in_valid && advance;
  assign req.ready = !in_valid || advance;

  fatlb_table u_table (
    .clk    (clk),
    .rst    (rst),
    .key    (in_key),
    .commit (process),
    .look   (look)
  );

  always_comb begin
    res_next.hit             = look.hit;
    res_next.page_number     = PnWidth'(in_key >> OFFSET_BITS);
    res_next.page_offset     = PoWidth'(in_key & OffsetMask);
    res_next.slot            = SlotWidth'(look.slot);
    res_next.evicted         = look.evicted;
    res_next.evicted_address = VaWidth'(look.evicted_address);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_key <= KeyBits'(req.virtual_address);
    end
    if (process) begin
      out_res <= res_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.hit             = out_res.hit;
  assign rsp.page_number     = out_res.page_number;
  assign rsp.page_offset     = out_res.page_offset;
  assign rsp.slot            = out_res.slot;
  assign rsp.evicted         = out_res.evicted;
  assign rsp.evicted_address = out_res.evicted_address;

endmodule

/* rtl/fatlb_table.sv */
// Entry store with parallel match, FIFO insert pointer and eviction select.
module fatlb_table (
  input  logic               clk,
  input  logic               rst,
  input  fatlb_pkg::key_t    key,
  input  logic               commit,
  output fatlb_pkg::lookup_t look
);
  import fatlb_pkg::*;

  key_t               entry_address [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  slot_t              oldest_slot;
  count_t             fill_count;

  logic [ENTRIES-1:0] match;
  logic               hit;
  slot_t              hit_slot;
  logic               full;
  logic [SumBits-1:0] free_sum;
  slot_t              free_slot;
  slot_t              ins_slot;
  slot_t              oldest_inc;

  always_comb begin
    hit_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_address[i] == key);
      if (match[i]) begin
        hit_slot = slot_t'(i);
      end
    end
  end

  assign hit  = |match;
  assign full = (fill_count == count_t'(ENTRIES));

  assign free_sum  = SumBits'(oldest_slot) + SumBits'(fill_count);
  assign free_slot = (free_sum >= SumBits'(ENTRIES)) ?
                     SlotBits'(free_sum - SumBits'(ENTRIES)) : SlotBits'(free_sum);
  assign ins_slot  = full ? oldest_slot : free_slot;
  assign oldest_inc = (oldest_slot == slot_t'(ENTRIES - 1)) ? '0 : oldest_slot + slot_t'(1);

  assign look.hit             = hit;
  assign look.slot            = hit ? hit_slot : ins_slot;
  assign look.evicted         = !hit && full;
  assign look.evicted_address = (!hit && full) ? entry_address[oldest_slot] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      oldest_slot <= '0;
      fill_count  <= '0;
    end else if (commit && !hit) begin
      entry_valid[ins_slot] <= 1'b1;
      if (full) begin
        oldest_slot <= oldest_inc;
      end else begin
        fill_count <= fill_count + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && !hit) begin
      entry_address[ins_slot] <= key;
    end
  end

endmodule
